/* hw/rtl/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, types and address helpers for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = ROWS * COLUMNS;
	localparam int ADDR_W  = $clog2(CELLS);
	localparam int ROW_W   = $clog2(ROWS);
	localparam int COL_W   = $clog2(COLUMNS);

	localparam logic [7:0] CH_NUL      = 8'h00;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_NL       = 8'h0A;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] RESET_COLOR = 8'h07;

	localparam logic OP_PUT  = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] addr;
		logic [15:0]       wdata;
	} tcw_mem_req_t;

	typedef struct packed {
		logic        valid;
		logic [15:0] cell_data;
		logic [4:0]  cursor_row;
		logic [6:0]  cursor_col;
	} tcw_result_t;

	function automatic logic [ROW_W-1:0] wrap_row(input logic [ROW_W-1:0] row,
	                                               input logic [ROW_W-1:0] base);
		logic [ROW_W:0] sum;
		sum = {1'b0, row} + {1'b0, base};
		if (sum >= (ROW_W+1)'(ROWS)) begin
			sum = sum - (ROW_W+1)'(ROWS);
		end
		return sum[ROW_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
	                                                 input logic [COL_W-1:0] col);
		logic [ADDR_W-1:0] a;
		a = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
		return a;
	endfunction

endpackage

/* hw/rtl/tcw_screen_ram.sv */
// ----------------------------------------------------------------------------
// tcw_screen_ram
// Single-port screen cell memory with a registered read.
// ----------------------------------------------------------------------------
module tcw_screen_ram (
	input  logic                 clk,
	input  tcw_pkg::tcw_mem_req_t req,
	output logic [15:0]          rdata
);
	import tcw_pkg::*;

	logic [15:0] mem [CELLS];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.addr] <= req.wdata;
		end
		rdata <= mem[req.addr];
	end

endmodule

/* hw/rtl/tcw_seq.sv */
// ----------------------------------------------------------------------------
// tcw_seq
// Request sequencer: cursor, scroll base, screen clear and row clear passes.
// ----------------------------------------------------------------------------
module tcw_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  opcode,
	input  logic [7:0]            char_code,
	input  logic [4:0]            cell_row,
	input  logic [6:0]            cell_col,
	input  logic                  cfg_wr_en,
	input  logic [7:0]            cfg_wr_data,
	input  logic                  out_free,
	output tcw_pkg::tcw_result_t  res,
	output tcw_pkg::tcw_mem_req_t mem_req,
	input  logic [15:0]           mem_rdata
);
	import tcw_pkg::*;

	typedef enum logic [4:0] {
		ST_INIT = 5'b00001,
		ST_IDLE = 5'b00010,
		ST_EXEC = 5'b00100,
		ST_CLR  = 5'b01000,
		ST_DONE = 5'b10000
	} tcw_state_t;

	tcw_state_t        state_q, state_d;
	logic [ROW_W-1:0]  cur_y_q, base_q, clr_row_q;
	logic [COL_W-1:0]  cur_x_q, clr_col_q;
	logic [7:0]        color_q, ch_q;
	logic              op_q, rd_ok_q;
	logic [1:0]        spaces_q;
	logic [ADDR_W-1:0] init_cnt_q;
	logic [15:0]       cell_hold_q;

	logic              accept, is_nul, is_nl, adv_row, scroll, step_move, fin;
	logic              init_last, clr_last, rd_ok;
	logic [7:0]        put_char;
	logic [COL_W:0]    x_inc;
	logic [ROW_W:0]    y_inc;
	logic [COL_W-1:0]  x_n;
	logic [ROW_W-1:0]  y_n;
	logic [15:0]       exec_cell;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign rd_ok     = (int'(cell_row) < ROWS) && (int'(cell_col) < COLUMNS);

	assign is_nul    = (ch_q == CH_NUL);
	assign is_nl     = (ch_q == CH_NL);
	assign put_char  = (ch_q == CH_TAB) ? CH_SPACE : ch_q;
	assign x_inc     = {1'b0, cur_x_q} + (COL_W+1)'(1);
	assign y_inc     = {1'b0, cur_y_q} + (ROW_W+1)'(1);
	assign adv_row   = is_nl || (x_inc >= (COL_W+1)'(COLUMNS));
	assign scroll    = adv_row && (y_inc >= (ROW_W+1)'(ROWS));
	assign x_n       = adv_row ? '0 : x_inc[COL_W-1:0];
	assign y_n       = (adv_row && !scroll) ? y_inc[ROW_W-1:0] : cur_y_q;
	assign step_move = (state_q == ST_EXEC) && (op_q == OP_PUT) && !is_nul;

	assign init_last = (init_cnt_q == ADDR_W'(CELLS - 1));
	assign clr_last  = (clr_col_q == COL_W'(COLUMNS - 1));
	assign exec_cell = ((op_q == OP_READ) && rd_ok_q) ? mem_rdata : 16'h0000;

	always_comb begin
		fin = 1'b0;
		case (state_q)
			ST_EXEC: fin = (op_q == OP_READ) || is_nul || (!scroll && (spaces_q == 2'd0));
			ST_CLR:  fin = clr_last && (spaces_q == 2'd0);
			ST_DONE: fin = 1'b1;
			default: fin = 1'b0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: if (init_last) state_d = ST_IDLE;
			ST_IDLE: if (accept) state_d = ST_EXEC;
			ST_EXEC: begin
				if (fin) begin
					state_d = out_free ? ST_IDLE : ST_DONE;
				end else if (scroll) begin
					state_d = ST_CLR;
				end
			end
			ST_CLR: begin
				if (fin) begin
					state_d = out_free ? ST_IDLE : ST_DONE;
				end else if (clr_last) begin
					state_d = ST_EXEC;
				end
			end
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_INIT;
		endcase
	end

	always_comb begin
		mem_req.wr_en = 1'b0;
		mem_req.addr  = cell_addr(wrap_row(cur_y_q, base_q), cur_x_q);
		mem_req.wdata = {color_q, put_char};
		case (state_q)
			ST_INIT: begin
				mem_req.wr_en = 1'b1;
				mem_req.addr  = init_cnt_q;
				mem_req.wdata = {RESET_COLOR, CH_SPACE};
			end
			ST_IDLE: begin
				mem_req.addr = cell_addr(wrap_row(ROW_W'(cell_row), base_q), COL_W'(cell_col));
			end
			ST_EXEC: begin
				mem_req.wr_en = step_move && !is_nl;
			end
			ST_CLR: begin
				mem_req.wr_en = 1'b1;
				mem_req.addr  = cell_addr(clr_row_q, clr_col_q);
				mem_req.wdata = {color_q, CH_SPACE};
			end
			default: mem_req.wr_en = 1'b0;
		endcase
	end

	always_comb begin
		res.valid      = fin && out_free;
		res.cell_data  = (state_q == ST_EXEC) ? exec_cell : cell_hold_q;
		res.cursor_row = step_move ? 5'(y_n) : 5'(cur_y_q);
		res.cursor_col = step_move ? 7'(x_n) : 7'(cur_x_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			cur_y_q    <= '0;
			cur_x_q    <= '0;
			base_q     <= '0;
			color_q    <= RESET_COLOR;
			spaces_q   <= '0;
			init_cnt_q <= '0;
			clr_col_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				color_q <= cfg_wr_data;
			end
			if (state_q == ST_INIT) begin
				init_cnt_q <= init_cnt_q + ADDR_W'(1);
			end
			if (accept) begin
				spaces_q <= ((opcode == OP_PUT) && (char_code == CH_TAB)) ? 2'd3 : 2'd0;
			end
			if (step_move) begin
				cur_x_q <= x_n;
				cur_y_q <= y_n;
				if (scroll) begin
					base_q    <= wrap_row(ROW_W'(1), base_q);
					clr_col_q <= '0;
				end else if (spaces_q != 2'd0) begin
					spaces_q <= spaces_q - 2'd1;
				end
			end
			if (state_q == ST_CLR) begin
				clr_col_q <= clr_col_q + COL_W'(1);
				if (clr_last && (spaces_q != 2'd0)) begin
					spaces_q <= spaces_q - 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= opcode;
			ch_q    <= char_code;
			rd_ok_q <= rd_ok;
		end
		if (step_move && scroll) begin
			clr_row_q <= base_q;
		end
		if (state_q == ST_EXEC) begin
			cell_hold_q <= exec_cell;
		end
	end

	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(cur_y_q) < ROWS) && (int'(cur_x_q) < COLUMNS))
		else $error("cursor out of screen");

	a_base_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(base_q) < ROWS)
		else $error("row base out of range");

	a_init_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_INIT) |=> (state_q != ST_INIT))
		else $error("clear pass restarted");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.wr_en |-> (int'(mem_req.addr) < CELLS))
		else $error("screen write out of range");

	a_result_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && !out_free |=> (state_q == ST_DONE))
		else $error("result dropped while output busy");

endmodule

/* hw/rtl/text_console_writer_core.sv */
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text console: screen memory with rotating row base, cursor, result register.
// ----------------------------------------------------------------------------
// A read or a plain put is carried out in the execute state, then its result
// is registered. Each scroll adds a pass that clears the bottom row through
// the single memory port; a tab is four put steps, each may scroll. No new
// request is taken until the previous result is registered.
// Reset: a clearing pass of ROWS*COLUMNS cells (2000) fills the screen with
// blanks in color 7 while in_stall is high; configuration writes still land.
module text_console_writer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [7:0]  char_code,
	input  logic [4:0]  cell_row,
	input  logic [6:0]  cell_col,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] cell_data,
	output logic [4:0]  cursor_row,
	output logic [6:0]  cursor_col,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data
);
	import tcw_pkg::*;

	tcw_result_t  res;
	tcw_mem_req_t mem_req;
	logic [15:0]  mem_rdata;
	logic         out_free;
	logic         out_valid_q;
	logic [15:0]  cell_data_q;
	logic [4:0]   cursor_row_q;
	logic [6:0]   cursor_col_q;

	assign out_free = !out_valid_q || !out_stall;

	tcw_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.char_code   (char_code),
		.cell_row    (cell_row),
		.cell_col    (cell_col),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_free    (out_free),
		.res         (res),
		.mem_req     (mem_req),
		.mem_rdata   (mem_rdata)
	);

	tcw_screen_ram u_ram (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			cell_data_q  <= res.cell_data;
			cursor_row_q <= res.cursor_row;
			cursor_col_q <= res.cursor_col;
		end
	end

	assign out_valid  = out_valid_q;
	assign cell_data  = cell_data_q;
	assign cursor_row = cursor_row_q;
	assign cursor_col = cursor_col_q;

endmodule

/* tb/text_console_writer_core_tb.sv */
// ----------------------------------------------------------------------------
// text_console_writer_core_tb
// Self-checking bench for the text console: puts, control characters, wrap,
// scroll and cell reads, in most phases under random idling on both channels,
// with the text color changed between phases. Every result is compared with
// an in-bench model of the screen, the cursor and the color register.
// ----------------------------------------------------------------------------
module text_console_writer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tcw_pkg::*;

	typedef struct {
		logic [15:0] data;
		logic [4:0]  row;
		logic [6:0]  col;
	} console_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        opcode;
	logic [7:0]  char_code;
	logic [4:0]  cell_row;
	logic [6:0]  cell_col;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] cell_data;
	logic [4:0]  cursor_row;
	logic [6:0]  cursor_col;
	logic        cfg_wr_en;
	logic [7:0]  cfg_wr_data;

	logic [15:0]     screen [CELLS];
	int              cur_y;
	int              cur_x;
	logic [7:0]      color;
	console_result_t expected_results [$];

	bit idle_on;
	int errors;
	int n_put;
	int n_read;
	int n_scroll;
	int n_cfg;

	text_console_writer_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.char_code  (char_code),
		.cell_row   (cell_row),
		.cell_col   (cell_col),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cell_data  (cell_data),
		.cursor_row (cursor_row),
		.cursor_col (cursor_col),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic void scroll_screen();
		for (int i = 0; i < CELLS - COLUMNS; i++) begin
			screen[i] = screen[i + COLUMNS];
		end
		for (int x = 0; x < COLUMNS; x++) begin
			screen[CELLS - COLUMNS + x] = {color, CH_SPACE};
		end
		n_scroll++;
	endfunction

	function automatic void place_glyph(input logic [7:0] ch);
		if (ch == CH_NUL) begin
			return;
		end
		if (ch == CH_NL) begin
			cur_x = 0;
			cur_y++;
		end else begin
			screen[cur_y * COLUMNS + cur_x] = {color, ch};
			cur_x++;
		end
		if (cur_x >= COLUMNS) begin
			cur_x = 0;
			cur_y++;
		end
		if (cur_y >= ROWS) begin
			cur_y = ROWS - 1;
			scroll_screen();
		end
	endfunction

	function automatic console_result_t predict_result(input logic op, input logic [7:0] ch,
	                                                   input logic [4:0] r, input logic [6:0] c);
		console_result_t res;
		res.data = 16'h0000;
		if (op == OP_PUT) begin
			if (ch == CH_TAB) begin
				repeat (4) place_glyph(CH_SPACE);
			end else begin
				place_glyph(ch);
			end
			n_put++;
		end else begin
			if (r < ROWS && c < COLUMNS) begin
				res.data = screen[r * COLUMNS + c];
			end
			n_read++;
		end
		res.row = 5'(cur_y);
		res.col = 7'(cur_x);
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (errors < 50) begin
			$display("MISMATCH %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $realtime);
		end
		errors++;
	endtask

	always @(negedge clk) begin
		out_stall <= idle_on && ($urandom_range(0, 99) < 24);
	end

	always @(posedge clk) begin : check_results
		console_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with no request pending", cell_data, 0);
			end else begin
				want = expected_results.pop_front();
				if (cell_data !== want.data) begin
					report_mismatch("cell_data", cell_data, want.data);
				end
				if (cursor_row !== want.row) begin
					report_mismatch("cursor_row", cursor_row, want.row);
				end
				if (cursor_col !== want.col) begin
					report_mismatch("cursor_col", cursor_col, want.col);
				end
			end
		end
	end

	task automatic send_request(input logic op, input logic [7:0] ch,
	                            input logic [4:0] r, input logic [6:0] c);
		while (idle_on && $urandom_range(0, 99) < 24) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		opcode    <= op;
		char_code <= ch;
		cell_row  <= r;
		cell_col  <= c;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		expected_results.push_back(predict_result(op, ch, r, c));
		@(negedge clk);
	endtask

	task automatic put_char(input logic [7:0] ch);
		send_request(OP_PUT, ch, 5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
	endtask

	task automatic read_cell(input logic [4:0] r, input logic [6:0] c);
		send_request(OP_READ, 8'($urandom_range(0, 255)), r, c);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0 || in_stall) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic set_color(input logic [7:0] c);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= c;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		color = c;
		n_cfg++;
	endtask

	function automatic logic [7:0] pick_char(input int nl_pct);
		int k;
		k = $urandom_range(0, 99);
		if (k < nl_pct) begin
			return CH_NL;
		end else if (k < nl_pct + 5) begin
			return CH_TAB;
		end else if (k < nl_pct + 8) begin
			return CH_NUL;
		end else if (k < nl_pct + 20) begin
			return 8'($urandom_range(0, 255));
		end
		return 8'($urandom_range(8'h21, 8'h7E));
	endfunction

	task automatic test_reset_screen();
		read_cell(5'd0, 7'd0);
		read_cell(5'd24, 7'd79);
		read_cell(5'd12, 7'd40);
		read_cell(5'd25, 7'd0);
		read_cell(5'd0, 7'd80);
		read_cell(5'd31, 7'd127);
	endtask

	task automatic test_put_controls();
		put_char(8'h41);
		put_char(8'hFF);
		put_char(8'h01);
		put_char(CH_NUL);
		put_char(CH_TAB);
		put_char(CH_NL);
		put_char(8'h7E);
		read_cell(5'd0, 7'd0);
		read_cell(5'd0, 7'd1);
		read_cell(5'd0, 7'd2);
		read_cell(5'd0, 7'd3);
		read_cell(5'd0, 7'd6);
		read_cell(5'd1, 7'd0);
	endtask

	task automatic test_color_extremes();
		set_color(8'h00);
		put_char(8'h78);
		set_color(8'hFF);
		put_char(8'h79);
		read_cell(5'd1, 7'd1);
		read_cell(5'd1, 7'd2);
	endtask

	task automatic run_traffic(input int count, input int nl_pct, input int read_pct);
		int sel;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < read_pct) begin
				sel = $urandom_range(0, 9);
				if (sel < 5) begin
					read_cell(5'(cur_y), 7'($urandom_range(0, COLUMNS - 1)));
				end else if (sel < 9) begin
					read_cell(5'($urandom_range(0, ROWS - 1)), 7'($urandom_range(0, COLUMNS - 1)));
				end else begin
					read_cell(5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
				end
			end else begin
				put_char(pick_char(nl_pct));
			end
		end
	endtask

	task automatic test_random_traffic();
		set_color(8'($urandom_range(0, 255)));
		run_traffic(200, 8, 25);
		set_color(8'h00);
		idle_on = 1'b0;
		run_traffic(150, 1, 15);
		idle_on = 1'b1;
		set_color(8'hFF);
		run_traffic(200, 20, 25);
		set_color(8'($urandom_range(0, 255)));
		run_traffic(200, 5, 40);
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		opcode      = OP_PUT;
		char_code   = CH_NUL;
		cell_row    = 5'd0;
		cell_col    = 7'd0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = 8'h00;
		idle_on     = 1'b1;
		errors      = 0;
		n_put       = 0;
		n_read      = 0;
		n_scroll    = 0;
		n_cfg       = 0;
		cur_y       = 0;
		cur_x       = 0;
		color       = RESET_COLOR;
		for (int i = 0; i < CELLS; i++) begin
			screen[i] = {RESET_COLOR, CH_SPACE};
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_screen();
		test_put_controls();
		test_color_extremes();
		test_random_traffic();

		wait_idle();
		repeat (20) @(posedge clk);
		$display("Covered %0d puts and %0d reads with %0d scrolls", n_put, n_read, n_scroll);
		$display("across %0d text color settings, including 0x00 and 0xFF", n_cfg + 1);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Timeout with %0d results outstanding", expected_results.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule

/* text_console_writer_core.f */
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_screen_ram.sv
hw/rtl/tcw_seq.sv
hw/rtl/text_console_writer_core.sv
tb/text_console_writer_core_tb.sv
